>>> rtl/fpatanh_pkg.sv
// Package for the fixed-point atanh pipeline: formats, coefficients, status codes
// and the arithmetic helpers used by the pipeline stages. No dependencies.
package fpatanh_pkg;

    localparam int IN_FRAC_BITS  = 30;
    localparam int OUT_FRAC_BITS = 26;
    localparam int WORK_FRAC     = 62;
    localparam int POLY_FRAC     = 54;
    localparam int LOG_FRAC      = 56;

    localparam logic [63:0]  LN2_Q62   = 64'h2C5C85FDF473DE6B;
    localparam logic [63:0]  TINY_Q62  = 64'd461168601843;
    localparam logic [127:0] DEC_SCALE = 128'd10000000000000000;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_POS_INF = 2'd1;
    localparam logic [1:0] ST_NEG_INF = 2'd2;
    localparam logic [1:0] ST_DOMAIN  = 2'd3;

    typedef enum logic [2:0] {
        CLS_TINY,
        CLS_POLY,
        CLS_LOG,
        CLS_INF,
        CLS_DOMAIN
    } t_cls;

    typedef struct packed {
        logic [63:0]       y;
        logic signed [7:0] pb;
    } t_norm;

    typedef struct packed {
        logic [127:0] dn;
        logic [63:0]  rem;
        logic [63:0]  quo;
    } t_div;

    typedef struct packed {
        logic [63:0] y;
        logic [55:0] f;
    } t_sq;

    // 32x32 partial products of a 64x64 multiply
    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } t_pp;

    // decimal coefficient (scaled by 1e16) to Q.54, rounded half away from zero
    function automatic logic signed [63:0] coef_q54(input logic signed [63:0] dec);
        logic [63:0]  mg;
        logic [127:0] n;
        logic [63:0]  q;
        mg = dec[63] ? 64'(-dec) : 64'(dec);
        n  = {64'b0, mg} << POLY_FRAC;
        n  = n + (DEC_SCALE >> 1);
        q  = 64'(n / DEC_SCALE);
        return dec[63] ? -$signed(q) : $signed(q);
    endfunction

    localparam logic signed [63:0] NUM_Q54 [5] = '{
        coef_q54(-64'sd8540743319296693),
        coef_q54(64'sd120426861384072379),
        coef_q54(-64'sd461252884198732693),
        coef_q54(64'sd654566728676544377),
        coef_q54(-64'sd309092539379866943)
    };
    localparam logic signed [63:0] DEN_Q54 [5] = '{
        coef_q54(-64'sd195638849376911655),
        coef_q54(64'sd1089380921471402627),
        coef_q54(-64'sd2498394013258935829),
        coef_q54(64'sd2520066756913445558),
        coef_q54(-64'sd927277618139601130)
    };

    function automatic t_pp mul_pp(input logic [63:0] a, input logic [63:0] b);
        t_pp r;
        r.ll = {32'b0, a[31:0]}  * {32'b0, b[31:0]};
        r.lh = {32'b0, a[31:0]}  * {32'b0, b[63:32]};
        r.hl = {32'b0, a[63:32]} * {32'b0, b[31:0]};
        r.hh = {32'b0, a[63:32]} * {32'b0, b[63:32]};
        return r;
    endfunction

    // sum partial products, round half up at bit s-1, shift right by s
    function automatic logic [63:0] pp_round(input t_pp pp, input logic [6:0] s);
        logic [127:0] p;
        p = {64'b0, pp.ll} + {32'b0, pp.lh, 32'b0} + {32'b0, pp.hl, 32'b0}
          + {pp.hh, 64'b0} + (128'd1 << (s - 7'd1));
        return 64'(p >> s);
    endfunction

    function automatic t_norm norm_log(input logic [63:0] v);
        t_norm      r;
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        r.y  = (p == 6'd63) ? (v >> 1) : (v << (6'd62 - p));
        r.pb = $signed({2'b00, p}) - 8'sd62;
        return r;
    endfunction

    function automatic t_sq sq_fin(input logic [55:0] f, input t_pp pp);
        t_sq r;
        r.y = pp_round(pp, 7'(WORK_FRAC));
        r.f = {f[54:0], 1'b0};
        if (r.y[63]) begin
            r.y    = r.y >> 1;
            r.f[0] = 1'b1;
        end
        return r;
    endfunction

    // four restoring division steps, numerator consumed from the top
    function automatic t_div div4(input t_div a, input logic [63:0] d);
        t_div r;
        logic bit_in;
        logic carry;
        r = a;
        for (int i = 0; i < 4; i++) begin
            bit_in = r.dn[127];
            r.dn   = r.dn << 1;
            carry  = r.rem[63];
            r.rem  = {r.rem[62:0], bit_in};
            r.quo  = r.quo << 1;
            if (carry || r.rem >= d) begin
                r.rem    = r.rem - d;
                r.quo[0] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] emit(input logic neg, input logic [63:0] mag,
                                         input logic [6:0] frac);
        logic [6:0]  sh;
        logic [63:0] mg;
        logic [63:0] lim;
        sh  = frac - 7'(OUT_FRAC_BITS);
        mg  = (mag + (64'd1 << (sh - 7'd1))) >> sh;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (mg > lim) begin
            mg = lim;
        end
        return neg ? 32'(-mg) : mg[31:0];
    endfunction

endpackage

>>> rtl/fixed_point_atanh_unit.sv
// Fixed-point atanh pipeline top level.
// Uses fpatanh_pkg for formats, coefficients and arithmetic helpers.
//
// Takes x in signed Q1.30 and returns atanh(x) in signed Q5.26 with a status code.
// One item is accepted every cycle while the output is not stalled. The pipeline
// depth is set by the 56 squaring steps of the log2 unit that serves arguments of
// magnitude 0.5 and above, two stages per step (32x32 partial products, then sum
// and round); the rational path (Horner stages and a 32-stage divider, four
// quotient bits per stage) runs alongside it. A stalled output holds the whole
// pipeline. |x| = 1 saturates with an infinity status, |x| > 1 gives zero with a
// domain status.
module fixed_point_atanh_unit
    import fpatanh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_arg_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_result_status
);

    localparam int NST      = 119;
    localparam int K_ZPP    = 1;
    localparam int K_ZFIN   = 2;
    localparam int K_HORNER = 3;
    localparam int K_SQ0    = 3;
    localparam int K_DIVSET = 13;
    localparam int K_DIV    = 14;
    localparam int K_T1PP   = 46;
    localparam int K_T1     = 47;
    localparam int K_T2PP   = 48;
    localparam int K_T2     = 49;
    localparam int K_SUM    = 50;
    localparam int K_SQ_END = 114;
    localparam int K_DIFF   = 115;
    localparam int K_LNPP   = 116;
    localparam int K_LNMUL  = 117;
    localparam int K_OUT    = 118;

    typedef struct packed {
        logic              neg;
        t_cls              cls;
        logic [63:0]       m;
        logic [63:0]       z54;
        logic [63:0]       z62;
        logic signed [63:0] pn;
        logic signed [63:0] qd;
        t_div              dv;
        logic [63:0]       qm;
        logic              rneg;
        logic [63:0]       tv;
        t_sq               la;
        t_sq               lb;
        logic signed [7:0] pb;
        logic [63:0]       mag;
        logic              mneg;
        logic [31:0]       res;
        logic [1:0]        st;
        t_pp               ppa;
        t_pp               ppb;
        t_pp               ppc;
        t_pp               ppd;
    } t_item;

    t_item r_pipe [NST];
    t_item n_pipe [NST];
    logic  r_vld  [NST];
    logic  w_en;

    assign w_en    = !(r_vld[NST-1] && i_stall);
    assign o_stall = !w_en;

    for (genvar K = 0; K < NST; K++) begin : g_stage
        localparam int JH = (K >= K_HORNER && K < K_HORNER + 10) ? (K - K_HORNER) / 2 : 0;

        if (K == 0) begin : g_dec
            always_comb begin
                logic [32:0] mg;
                n_pipe[0]     = r_pipe[0];
                n_pipe[0].neg = i_arg_value[31];
                mg = i_arg_value[31] ? (33'h1_0000_0000 - {1'b0, i_arg_value})
                                     : {1'b0, i_arg_value};
                n_pipe[0].m    = 64'(mg) << (WORK_FRAC - IN_FRAC_BITS);
                n_pipe[0].mag  = 64'(mg) << (WORK_FRAC - IN_FRAC_BITS);
                n_pipe[0].mneg = i_arg_value[31];
                if (mg > (33'd1 << IN_FRAC_BITS)) begin
                    n_pipe[0].cls = CLS_DOMAIN;
                end else if (mg == (33'd1 << IN_FRAC_BITS)) begin
                    n_pipe[0].cls = CLS_INF;
                end else if (n_pipe[0].m < TINY_Q62) begin
                    n_pipe[0].cls = CLS_TINY;
                end else if (n_pipe[0].m < (64'd1 << 61)) begin
                    n_pipe[0].cls = CLS_POLY;
                end else begin
                    n_pipe[0].cls = CLS_LOG;
                end
            end
        end else begin : g_work
            always_comb begin
                t_item p;
                t_norm nb;
                logic [63:0] t;
                logic [63:0] mg;
                logic signed [63:0] s;
                logic signed [63:0] lbv;
                p   = r_pipe[K-1];
                nb  = '0;
                t   = '0;
                mg  = '0;
                s   = '0;
                lbv = '0;
                if (K == K_ZPP) begin
                    p.ppc = mul_pp(p.m, p.m);
                end
                if (K == K_ZFIN) begin
                    nb     = norm_log((64'd1 << WORK_FRAC) - p.m);
                    p.z54  = pp_round(p.ppc, 7'(2 * WORK_FRAC - POLY_FRAC));
                    p.z62  = pp_round(p.ppc, 7'(WORK_FRAC));
                    p.pn   = NUM_Q54[0];
                    p.qd   = 64'sd1 <<< POLY_FRAC;
                    p.la.y = (64'd1 << WORK_FRAC) + p.m;
                    p.la.f = '0;
                    p.lb.y = nb.y;
                    p.lb.f = '0;
                    p.pb   = nb.pb;
                end
                if (K >= K_HORNER && K < K_HORNER + 10) begin
                    if (((K - K_HORNER) % 2) == 0) begin
                        p.ppc = mul_pp(p.qd[63] ? 64'(-p.qd) : 64'(p.qd), p.z54);
                        p.ppd = mul_pp(p.pn[63] ? 64'(-p.pn) : 64'(p.pn), p.z54);
                    end else begin
                        mg   = pp_round(p.ppc, 7'(POLY_FRAC));
                        p.qd = (p.qd[63] ? -$signed(mg) : $signed(mg)) + DEN_Q54[JH];
                        if (K > K_HORNER + 1) begin
                            mg   = pp_round(p.ppd, 7'(POLY_FRAC));
                            p.pn = (p.pn[63] ? -$signed(mg) : $signed(mg)) + NUM_Q54[JH];
                        end
                    end
                end
                if (K >= K_SQ0 && K <= K_SQ_END) begin
                    if (((K - K_SQ0) % 2) == 0) begin
                        p.ppa = mul_pp(p.la.y, p.la.y);
                        p.ppb = mul_pp(p.lb.y, p.lb.y);
                    end else begin
                        p.la = sq_fin(p.la.f, p.ppa);
                        p.lb = sq_fin(p.lb.f, p.ppb);
                    end
                end
                if (K == K_DIVSET) begin
                    p.qm     = p.qd[63] ? 64'(-p.qd) : 64'(p.qd);
                    p.rneg   = p.pn[63] ^ p.qd[63];
                    p.dv.dn  = ({64'b0, (p.pn[63] ? 64'(-p.pn) : 64'(p.pn))} << 62)
                             + {65'b0, p.qm[63:1]};
                    p.dv.rem = '0;
                    p.dv.quo = '0;
                end
                if (K >= K_DIV && K < K_T1PP) begin
                    p.dv = div4(p.dv, p.qm);
                end
                if (K == K_T1PP) begin
                    p.ppc = mul_pp(p.m, p.z62);
                end
                if (K == K_T1) begin
                    p.tv = pp_round(p.ppc, 7'(WORK_FRAC));
                    if (p.qm == '0) begin
                        p.dv.quo = '0;
                    end
                end
                if (K == K_T2PP) begin
                    p.ppc = mul_pp(p.tv, p.dv.quo);
                end
                if (K == K_T2) begin
                    t = pp_round(p.ppc, 7'(WORK_FRAC));
                    p.tv = (t > (64'd1 << 62)) ? (64'd1 << 62) : t;
                end
                if (K == K_SUM && p.cls == CLS_POLY) begin
                    s = p.rneg ? ($signed(p.m) - $signed(p.tv))
                               : ($signed(p.m) + $signed(p.tv));
                    p.mneg = p.neg ^ s[63];
                    p.mag  = s[63] ? 64'(-s) : 64'(s);
                end
                if (K == K_DIFF) begin
                    lbv  = ($signed(64'(p.pb)) <<< LOG_FRAC) + $signed({8'b0, p.lb.f});
                    p.tv = 64'($signed({8'b0, p.la.f}) - lbv);
                end
                if (K == K_LNPP) begin
                    p.ppc = mul_pp(p.tv[63] ? 64'(-p.tv) : p.tv, LN2_Q62);
                end
                if (K == K_LNMUL && p.cls == CLS_LOG) begin
                    p.mag  = pp_round(p.ppc, 7'(WORK_FRAC + 1));
                    p.mneg = p.neg ^ p.tv[63];
                end
                if (K == K_OUT) begin
                    case (p.cls)
                        CLS_DOMAIN: begin
                            p.res = '0;
                            p.st  = ST_DOMAIN;
                        end
                        CLS_INF: begin
                            p.res = p.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                            p.st  = p.neg ? ST_NEG_INF : ST_POS_INF;
                        end
                        CLS_LOG: begin
                            p.res = emit(p.mneg, p.mag, 7'(LOG_FRAC));
                            p.st  = ST_OK;
                        end
                        default: begin
                            p.res = emit(p.mneg, p.mag, 7'(WORK_FRAC));
                            p.st  = ST_OK;
                        end
                    endcase
                end
                n_pipe[K] = p;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[K] <= 1'b0;
            end else if (w_en) begin
                r_vld[K] <= (K == 0) ? i_valid : r_vld[(K == 0) ? 0 : K-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pipe[K] <= n_pipe[K];
            end
        end
    end

    assign o_valid         = r_vld[NST-1];
    assign o_result_value  = r_pipe[NST-1].res;
    assign o_result_status = r_pipe[NST-1].st;

    a_domain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_status == ST_DOMAIN) |-> (o_result_value == '0))
        else $error("domain error item with nonzero value");

    a_pos_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_status == ST_POS_INF) |-> (o_result_value == 32'h7FFF_FFFF))
        else $error("positive infinity item not saturated");

    a_neg_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_status == ST_NEG_INF) |-> (o_result_value == 32'h8000_0000))
        else $error("negative infinity item not saturated");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-2] && o_stall) |=> r_vld[NST-2])
        else $error("item lost inside pipeline during stall");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for fixed_point_atanh_unit: drives Q1.30 arguments, predicts
// atanh in Q5.26 with status, and checks every result in order. Depends on fpatanh_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpatanh_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_arg_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result_value;
    logic [1:0]  o_result_status;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } t_atanh_res;

    logic [31:0] arg_queue[$];
    t_atanh_res  atanh_expected[$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 8;
    int          recv_idle_pct  = 69;
    bit          hold_send      = 0;

    fixed_point_atanh_unit u_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rmul(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        p = p + (128'd1 << (s - 1));
        return 64'(p >> s);
    endfunction

    function automatic logic signed [63:0] q54_of(logic signed [63:0] d);
        logic [127:0] n;
        logic [63:0]  q;
        n = {64'b0, (d < 0) ? 64'(-d) : 64'(d)} << 54;
        n = n + 128'd5000000000000000;
        q = 64'(n / 128'd10000000000000000);
        return (d < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [63:0] srmul(logic signed [63:0] a, logic [63:0] b);
        logic [63:0] mg;
        mg = rmul((a < 0) ? 64'(-a) : 64'(a), b, 54);
        return (a < 0) ? -$signed(mg) : $signed(mg);
    endfunction

    function automatic logic signed [63:0] log2_q56(logic [63:0] v);
        int          p;
        logic [63:0] y;
        logic [63:0] fr;
        p = 63;
        while (p > 0 && !v[p]) p--;
        y = (p > 62) ? (v >> 1) : (v << (62 - p));
        fr = 0;
        for (int i = 0; i < 56; i++) begin
            y = rmul(y, y, 62);
            fr = fr << 1;
            if (y[63]) begin
                y = y >> 1;
                fr[0] = 1;
            end
        end
        return (64'(signed'(p - 62)) <<< 56) + $signed(fr);
    endfunction

    function automatic logic [31:0] to_q526(bit neg, logic [63:0] mag, int fr);
        logic [63:0] lim;
        int          sh;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        sh = fr - 26;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (mag > lim) mag = lim;
        return neg ? 32'(-mag) : mag[31:0];
    endfunction

    function automatic t_atanh_res atanh_of(logic [31:0] x);
        t_atanh_res       r;
        bit               neg;
        logic [63:0]      mag, m, z54, z62, pm, qm, ratio, t, ur;
        logic signed [63:0] pn, qd, s, la, lb, d;
        logic signed [63:0] nd[5];
        logic signed [63:0] dd[5];
        bit               rneg;
        logic [127:0]     n;
        nd = '{-64'sd8540743319296693, 64'sd120426861384072379,
               -64'sd461252884198732693, 64'sd654566728676544377,
               -64'sd309092539379866943};
        dd = '{-64'sd195638849376911655, 64'sd1089380921471402627,
               -64'sd2498394013258935829, 64'sd2520066756913445558,
               -64'sd927277618139601130};
        neg = x[31];
        mag = neg ? (64'h1_0000_0000 - x) : {32'b0, x};
        r.status = ST_OK;
        if (mag > (64'd1 << 30)) begin
            r.value = 0;
            r.status = ST_DOMAIN;
            return r;
        end
        if (mag == (64'd1 << 30)) begin
            r.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r.status = neg ? ST_NEG_INF : ST_POS_INF;
            return r;
        end
        m = mag << 32;
        if (m < TINY_Q62) begin
            r.value = to_q526(neg, m, 62);
        end else if (m < (64'd1 << 61)) begin
            z54 = rmul(m, m, 70);
            z62 = rmul(m, m, 62);
            pn = q54_of(nd[0]);
            qd = 64'sd1 <<< 54;
            for (int i = 1; i < 5; i++) pn = srmul(pn, z54) + q54_of(nd[i]);
            for (int i = 0; i < 5; i++) qd = srmul(qd, z54) + q54_of(dd[i]);
            pm = (pn < 0) ? 64'(-pn) : 64'(pn);
            qm = (qd < 0) ? 64'(-qd) : 64'(qd);
            rneg = (pn < 0) != (qd < 0);
            ratio = 0;
            if (qm != 0) begin
                n = ({64'b0, pm} << 62) + {64'b0, qm >> 1};
                ratio = 64'(n / {64'b0, qm});
            end
            t = rmul(rmul(m, z62, 62), ratio, 62);
            if (t > (64'd1 << 62)) t = 64'd1 << 62;
            s = rneg ? $signed(m) - $signed(t) : $signed(m) + $signed(t);
            if (s < 0) begin
                neg = !neg;
                s = -s;
            end
            r.value = to_q526(neg, s, 62);
        end else begin
            la = log2_q56((64'd1 << 62) + m);
            lb = log2_q56((64'd1 << 62) - m);
            d = la - lb;
            ur = rmul((d < 0) ? 64'(-d) : 64'(d), LN2_Q62, 63);
            if (d < 0) neg = !neg;
            r.value = to_q526(neg, ur, 56);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            i_arg_value <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) atanh_expected.push_back(atanh_of(i_arg_value));
            if (arg_queue.size() != 0 && !hold_send
                && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1;
                i_arg_value <= arg_queue.pop_front();
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_atanh_res w;
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (atanh_expected.size() == 0) begin
                    report_mismatch("unexpected item", o_result_value, 32'h0);
                end else begin
                    w = atanh_expected.pop_front();
                    if (o_result_value !== w.value)
                        report_mismatch("value", o_result_value, w.value);
                    if (o_result_status !== w.status)
                        report_mismatch("status", 32'(o_result_status), 32'(w.status));
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [31:0] rand_arg();
        int k;
        k = $urandom_range(9);
        case (k)
            0, 1, 2: return 32'($urandom_range(32'h4000_0000)) ^ {32{$urandom_range(1) == 1}};
            3, 4: return 32'($urandom_range(32'h1FFF_FFFF));
            5: return $urandom_range(1) ? 32'($urandom_range(120)) : -32'($urandom_range(120));
            6: return $urandom_range(1) ? 32'h4000_0000 - $urandom_range(4000)
                                        : 32'hC000_0000 + $urandom_range(4000);
            7: return $urandom();
            default: return $urandom_range(1) ? 32'h2000_0000 + $urandom_range(9) - 5
                                              : 32'($urandom_range(32'h3FFF_FFFF));
        endcase
    endfunction

    task automatic drain();
        while (arg_queue.size() != 0 || i_valid || atanh_expected.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] directed[$];
        i_rst_n = 0;
        i_valid = 0;
        i_arg_value = 0;
        i_stall = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'd107, 32'd108, -32'd108,
                     32'h1FFF_FFFF, 32'h2000_0000, 32'hE000_0000, 32'h2000_0001,
                     32'h3FFF_FFFF, 32'hC000_0001, 32'h4000_0000, 32'hC000_0000,
                     32'h4000_0001, 32'hBFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0CCC_CCCD, 32'hD555_5555, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (directed[i]) arg_queue.push_back(directed[i]);
        for (int i = 0; i < 180; i++) arg_queue.push_back(rand_arg());
        drain();
        hold_send = 1;
        repeat (70) @(posedge i_clk);
        hold_send = 0;
        send_idle_pct = 69;
        recv_idle_pct = 8;
        for (int i = 0; i < 180; i++) arg_queue.push_back(rand_arg());
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 190; i++) arg_queue.push_back(rand_arg());
        drain();
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

>>> fixed_point_atanh_unit.f
rtl/fpatanh_pkg.sv
rtl/fixed_point_atanh_unit.sv
tb/sv/tb.sv
